// ----- rtl/spb_pkg.sv -----
// Shared types, constants and the semitone frequency table of the pitch binner.
// Used by the channel interfaces, the search cells, the finish stage and the top level.
package spb_pkg;

  localparam int NUM_BINS        = 108;
  localparam int BINS_PER_OCTAVE = 12;
  localparam int REF_FREQ_HZ     = 440;
  localparam int REF_INDEX       = 57;

  localparam int FREQ_W      = 20;
  localparam int PROB_W      = 16;
  localparam int TRUST_W     = 16;
  localparam int SUM_W       = 21;
  localparam int BIN_IDX_W   = 7;
  localparam int TABLE_DEPTH = 1 << BIN_IDX_W;
  localparam int BF_W        = 32;

  localparam int WEIGHT_W = TRUST_W + SUM_W;
  localparam int X_W      = 17;
  localparam int DIV_SH   = 24;
  localparam int PROD_W   = X_W + DIV_SH;
  localparam logic [DIV_SH-1:0] DIV_RECIP = DIV_SH'((1 << DIV_SH) / NUM_BINS);
  localparam logic [WEIGHT_W-1:0] ONE_Q32 = WEIGHT_W'(64'd1 << 32);

  localparam logic [31:0] SEMI_RATIO [BINS_PER_OCTAVE] = '{
    32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
    32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
    32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
  };

  typedef logic [BF_W-1:0] bin_table_t [TABLE_DEPTH];

  typedef struct packed {
    logic                 valid;
    logic [FREQ_W-1:0]    freq;
    logic [PROB_W-1:0]    prob;
    logic                 no_cand;
    logic                 frame_end;
    logic [BIN_IDX_W-1:0] pos;
    logic [BIN_IDX_W-1:0] step;
  } search_t;

  // Bin frequency in unsigned Q26.6 Hz, rounded half up.
  function automatic logic [BF_W-1:0] bin_freq(input int idx);
    int         d;
    int         oct;
    int         semi;
    int         sh;
    logic [63:0] v;
    logic [63:0] r;
    d    = idx - REF_INDEX + 11 * BINS_PER_OCTAVE;
    oct  = d / BINS_PER_OCTAVE - 11;
    semi = d % BINS_PER_OCTAVE;
    sh   = 30 - oct;
    v    = 64'(REF_FREQ_HZ) * 64'd64 * 64'(SEMI_RATIO[semi]);
    r    = (v + (64'd1 << (sh - 1))) >> sh;
    return BF_W'(r);
  endfunction

  // Entries past the last bin read as all ones so that the search never passes them.
  function automatic bin_table_t build_table();
    bin_table_t t;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      t[i] = (i < NUM_BINS) ? bin_freq(i) : '1;
    end
    return t;
  endfunction

  localparam bin_table_t BIN_FREQ = build_table();
  localparam logic [BF_W-1:0] TOP_FREQ = BIN_FREQ[NUM_BINS-1];

endpackage

// ----- rtl/spb_in_if.sv -----
// Candidate input channel: valid/ready handshake with one candidate item as payload.
// Depends on spb_pkg for the field widths.
interface spb_in_if;
  logic                      valid;
  logic                      ready;
  logic [spb_pkg::FREQ_W-1:0] candidate_freq;
  logic [spb_pkg::PROB_W-1:0] candidate_prob;
  logic                      no_candidate;
  logic                      frame_end;

  modport source(output valid, candidate_freq, candidate_prob, no_candidate, frame_end,
                 input ready);
  modport sink(input valid, candidate_freq, candidate_prob, no_candidate, frame_end,
               output ready);
endinterface

// ----- rtl/spb_out_if.sv -----
// Result output channel: valid/ready handshake with one binning result item as payload.
// Depends on spb_pkg for the field widths.
interface spb_out_if;
  logic                         valid;
  logic                         ready;
  logic [spb_pkg::BIN_IDX_W-1:0] bin_index;
  logic                         bin_valid;
  logic [spb_pkg::PROB_W-1:0]    voiced_prob;
  logic [spb_pkg::PROB_W-1:0]    unvoiced_prob;
  logic                         unvoiced_clamped;
  logic                         frame_done;

  modport source(output valid, bin_index, bin_valid, voiced_prob, unvoiced_prob,
                 unvoiced_clamped, frame_done, input ready);
  modport sink(input valid, bin_index, bin_valid, voiced_prob, unvoiced_prob,
               unvoiced_clamped, frame_done, output ready);
endinterface

// ----- rtl/spb_search_cell.sv -----
// One cell of the binary search chain: settles one bit of the lower-bound bin position.
// Depends on spb_pkg for the search item type and the bin frequency table.
module spb_search_cell (
  input  logic             clk,
  input  logic             rst,
  input  spb_pkg::search_t d,
  output spb_pkg::search_t q
);

  logic [spb_pkg::BIN_IDX_W-1:0] probe;
  logic [spb_pkg::BIN_IDX_W-1:0] probe_idx;
  logic                          below;

  // Probe the last entry of the lower half; if it is still below the frequency, take the upper half.
  assign probe     = d.pos | d.step;
  assign probe_idx = probe - spb_pkg::BIN_IDX_W'(1);
  assign below     = spb_pkg::BIN_FREQ[probe_idx] < spb_pkg::BF_W'(d.freq);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q.valid <= d.valid;
    end
    q.freq      <= d.freq;
    q.prob      <= d.prob;
    q.no_cand   <= d.no_cand;
    q.frame_end <= d.frame_end;
    q.pos       <= below ? probe : d.pos;
    q.step      <= d.step >> 1;
  end

endmodule

// ----- rtl/spb_finish.sv -----
// Finish stages: nearest-bin choice, probability weighting, frame sum and unvoiced value.
// Depends on spb_pkg and spb_out_if; holds the trust register and the output register.
module spb_finish (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [spb_pkg::TRUST_W-1:0]  cfg_wr_data,
  input  spb_pkg::search_t             d,
  output logic                         loaded,
  spb_out_if.source                    out_ch
);

  logic [spb_pkg::TRUST_W-1:0]   trust;
  logic [spb_pkg::SUM_W-1:0]     prob_sum;

  logic [spb_pkg::BIN_IDX_W-1:0] lo_idx;
  logic [spb_pkg::BF_W-1:0]      freq_ext;
  logic [spb_pkg::BF_W-1:0]      dist_up;
  logic [spb_pkg::BF_W-1:0]      dist_lo;
  logic [spb_pkg::BIN_IDX_W-1:0] near_idx;
  logic                          placed;
  logic [spb_pkg::SUM_W:0]       sum_wide;
  logic [spb_pkg::SUM_W-1:0]     sum_after;
  logic [2*spb_pkg::PROB_W-1:0]  trust_prob;

  logic                          f1_valid;
  logic [spb_pkg::BIN_IDX_W-1:0] f1_idx;
  logic                          f1_placed;
  logic [spb_pkg::PROB_W-1:0]    f1_voiced;
  logic                          f1_last;
  logic [spb_pkg::SUM_W-1:0]     f1_sum;

  logic                          f2_valid;
  logic [spb_pkg::BIN_IDX_W-1:0] f2_idx;
  logic                          f2_placed;
  logic [spb_pkg::PROB_W-1:0]    f2_voiced;
  logic                          f2_last;
  logic [spb_pkg::WEIGHT_W-1:0]  f2_weighted;

  logic [spb_pkg::WEIGHT_W-1:0]  diff;
  logic                          over;
  logic [spb_pkg::X_W-1:0]       x_val;

  logic                          f3_valid;
  logic [spb_pkg::BIN_IDX_W-1:0] f3_idx;
  logic                          f3_placed;
  logic [spb_pkg::PROB_W-1:0]    f3_voiced;
  logic                          f3_last;
  logic                          f3_clamped;
  logic [spb_pkg::X_W-1:0]       f3_x;
  logic [spb_pkg::PROD_W-1:0]    f3_prod;

  logic [spb_pkg::X_W-1:0]       q0;
  logic [spb_pkg::X_W+spb_pkg::BIN_IDX_W-1:0] q0_times_n;
  logic [spb_pkg::X_W-1:0]       rem;
  logic [spb_pkg::X_W-1:0]       quot;

  logic                          out_valid;
  logic [spb_pkg::BIN_IDX_W-1:0] out_idx;
  logic                          out_placed;
  logic [spb_pkg::PROB_W-1:0]    out_voiced;
  logic [spb_pkg::PROB_W-1:0]    out_unvoiced;
  logic                          out_clamped;
  logic                          out_done;

  // The position from the search is the first bin at or above the frequency.
  // The bin below wins only when strictly closer, so ties go upward.
  assign lo_idx   = d.pos - spb_pkg::BIN_IDX_W'(1);
  assign freq_ext = spb_pkg::BF_W'(d.freq);
  assign dist_up  = spb_pkg::BIN_FREQ[d.pos] - freq_ext;
  assign dist_lo  = freq_ext - spb_pkg::BIN_FREQ[lo_idx];
  assign near_idx = (d.pos == '0 || dist_up <= dist_lo) ? d.pos : lo_idx;
  assign placed   = !d.no_cand && freq_ext <= spb_pkg::TOP_FREQ;

  assign sum_wide   = {1'b0, prob_sum} + (spb_pkg::SUM_W + 1)'(d.prob);
  assign sum_after  = !placed ? prob_sum :
                      sum_wide[spb_pkg::SUM_W] ? '1 : sum_wide[spb_pkg::SUM_W-1:0];
  assign trust_prob = (2*spb_pkg::PROB_W)'(trust) * (2*spb_pkg::PROB_W)'(d.prob);

  always_ff @(posedge clk) begin
    if (rst) begin
      trust <= spb_pkg::TRUST_W'(32768);
    end else if (cfg_wr_en) begin
      trust <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prob_sum <= '0;
    end else if (d.valid) begin
      prob_sum <= d.frame_end ? '0 : sum_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      f1_valid <= d.valid;
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d.valid) begin
      f1_idx    <= placed ? near_idx : '0;
      f1_placed <= placed;
      f1_voiced <= placed ? trust_prob[2*spb_pkg::PROB_W-1:spb_pkg::PROB_W] : '0;
      f1_last   <= d.frame_end;
      f1_sum    <= sum_after;
    end
    if (f1_valid) begin
      f2_idx      <= f1_idx;
      f2_placed   <= f1_placed;
      f2_voiced   <= f1_voiced;
      f2_last     <= f1_last;
      f2_weighted <= spb_pkg::WEIGHT_W'(trust) * spb_pkg::WEIGHT_W'(f1_sum);
    end
  end

  // The quotient by NUM_BINS * 2^16 is the 16-bit-shifted difference divided by NUM_BINS.
  assign over  = f2_weighted > spb_pkg::ONE_Q32;
  assign diff  = spb_pkg::ONE_Q32 - f2_weighted;
  assign x_val = diff[spb_pkg::X_W+15:16];

  assign loaded = f3_valid && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      f3_valid <= 1'b0;
    end else if (f2_valid) begin
      f3_valid <= 1'b1;
    end else if (loaded) begin
      f3_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (f2_valid) begin
      f3_idx     <= f2_idx;
      f3_placed  <= f2_placed;
      f3_voiced  <= f2_voiced;
      f3_last    <= f2_last;
      f3_clamped <= f2_last && over;
      f3_x       <= over ? '0 : x_val;
      f3_prod    <= spb_pkg::PROD_W'(over ? '0 : x_val) * spb_pkg::PROD_W'(spb_pkg::DIV_RECIP);
    end
  end

  // The reciprocal estimate is low by at most one; one compare corrects it.
  assign q0         = f3_prod[spb_pkg::PROD_W-1:spb_pkg::DIV_SH];
  assign q0_times_n = (spb_pkg::X_W + spb_pkg::BIN_IDX_W)'(q0) *
                      (spb_pkg::X_W + spb_pkg::BIN_IDX_W)'(spb_pkg::NUM_BINS);
  assign rem        = f3_x - q0_times_n[spb_pkg::X_W-1:0];
  assign quot       = (rem >= spb_pkg::X_W'(spb_pkg::NUM_BINS)) ? q0 + spb_pkg::X_W'(1) : q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (loaded) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (loaded) begin
      out_idx      <= f3_idx;
      out_placed   <= f3_placed;
      out_voiced   <= f3_voiced;
      out_unvoiced <= (f3_last && !f3_clamped) ? quot[spb_pkg::PROB_W-1:0] : '0;
      out_clamped  <= f3_clamped;
      out_done     <= f3_last;
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.bin_index        = out_idx;
  assign out_ch.bin_valid        = out_placed;
  assign out_ch.voiced_prob      = out_voiced;
  assign out_ch.unvoiced_prob    = out_unvoiced;
  assign out_ch.unvoiced_clamped = out_clamped;
  assign out_ch.frame_done       = out_done;

`ifndef ASSERT_OFF
  a_clamp_only_at_frame_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_clamped) |-> out_done)
    else $error("clamped unvoiced value on an item that does not end the frame");

  a_one_item_in_finish: assert property (@(posedge clk) disable iff (rst)
    $onehot0({d.valid, f1_valid, f2_valid, f3_valid}))
    else $error("more than one item in the finish stages");

  a_dropped_has_no_weight: assert property (@(posedge clk) disable iff (rst)
    (f1_valid && !f1_placed) |-> (f1_voiced == '0 && f1_idx == '0))
    else $error("dropped candidate carries a bin or a weight");
`endif

endmodule

// ----- rtl/semitone_pitch_binner.sv -----
// Semitone pitch binner: a chain of seven search cells followed by three finish stages.
// Path: an accepted item passes the seven search cells, then the f1, f2 and f3 finish
// registers and the output register; f3 holds it while the output result is not taken.
// One item is in flight at a time; the next is taken once the last enters the output register.
// Reset (rst, synchronous) clears the frame sum and all valid bits and sets the trust
// register to 32768; there is no clearing pass.
module semitone_pitch_binner (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [spb_pkg::TRUST_W-1:0] cfg_wr_data,
  spb_in_if.sink                      in_ch,
  spb_out_if.source                   out_ch
);

  localparam int CELLS = spb_pkg::BIN_IDX_W;

  spb_pkg::search_t chain [CELLS+1];
  logic [CELLS-1:0] cell_valid;
  logic             busy;
  logic             accept;
  logic             loaded;

  assign in_ch.ready = !busy;
  assign accept      = in_ch.valid && !busy;

  assign chain[0].valid     = accept;
  assign chain[0].freq      = in_ch.candidate_freq;
  assign chain[0].prob      = in_ch.candidate_prob;
  assign chain[0].no_cand   = in_ch.no_candidate;
  assign chain[0].frame_end = in_ch.frame_end;
  assign chain[0].pos       = '0;
  assign chain[0].step      = CELLS'(1) << (CELLS - 1);

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    spb_search_cell u_cell (
      .clk (clk),
      .rst (rst),
      .d   (chain[k]),
      .q   (chain[k+1])
    );
    assign cell_valid[k] = chain[k+1].valid;
  end

  spb_finish u_finish (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .d           (chain[CELLS]),
    .loaded      (loaded),
    .out_ch      (out_ch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (loaded) begin
      busy <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input still ready after an item was accepted");

  a_one_item_in_chain: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_valid))
    else $error("more than one item in the search chain");

  a_chain_item_is_tracked: assert property (@(posedge clk) disable iff (rst)
    chain[CELLS].valid |-> busy)
    else $error("search result without an item in flight");
`endif

endmodule
